// ===== rtl/point_figure_column_builder_assert.svh =====
// Assertion macros for the point-and-figure column builder
`ifndef POINT_FIGURE_COLUMN_BUILDER_ASSERT_SVH
`define POINT_FIGURE_COLUMN_BUILDER_ASSERT_SVH

// same-cycle implication
`define PFCB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PFCB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pfcb_pkg.sv =====
// Shared types and constants for the point-and-figure column builder
`timescale 1ns / 1ps
package pfcb_pkg;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned BOX_W     = 32;
    localparam int unsigned REV_W     = 4;
    localparam int unsigned TURN_W    = 36;
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 3;
    localparam int unsigned ADDR_LSB  = 2;
    localparam logic [BOX_W-1:0] BOX_RESET = 32'd1;
    localparam logic [REV_W-1:0] REV_RESET = 4'd3;

    typedef enum logic {
        REG_BOX_SIZE  = 1'b0,
        REG_REVERSAL  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic first;
        logic last;
        logic rising;
    } t_bar_flags;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    typedef struct packed {
        logic [FIELD_W-1:0] column_top;
        logic [FIELD_W-1:0] column_bottom;
        logic               column_rising;
        logic               open_flushed;
        logic               last_of_run;
    } t_col_res;

endpackage

// ===== rtl/pfcb_if.sv =====
// Request channels: price bars in, finished columns out
`timescale 1ns / 1ps
interface pfcb_bar_if;
    import pfcb_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] bar_high;
    logic [FIELD_W-1:0] bar_low;
    logic [FIELD_W-1:0] bar_close;
    logic               first_bar;
    logic               last_bar;

    modport source (output valid, bar_high, bar_low, bar_close, first_bar, last_bar,
                    input ready);
    modport sink   (input valid, bar_high, bar_low, bar_close, first_bar, last_bar,
                    output ready);
endinterface

interface pfcb_col_if;
    import pfcb_pkg::*;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] column_top;
    logic [FIELD_W-1:0] column_bottom;
    logic               column_rising;
    logic               open_flushed;
    logic               last_of_run;

    modport source (output valid, column_top, column_bottom, column_rising, open_flushed,
                    last_of_run, input ready);
    modport sink   (input valid, column_top, column_bottom, column_rising, open_flushed,
                    last_of_run, output ready);
endinterface

// ===== rtl/pfcb_fifo.sv =====
// Small register queue between the front and back halves
`timescale 1ns / 1ps
module pfcb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2   // power of two
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [WIDTH-1:0]       i_data,
    input  logic                   i_pop,
    output logic [WIDTH-1:0]       o_data,
    output pfcb_pkg::t_fifo_stat   o_stat
);
    import pfcb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== rtl/pfcb_front.sv =====
// Front half: takes bars and floors high and low to the box grid bit-serially
`timescale 1ns / 1ps
module pfcb_front #(
    parameter int PRICE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pfcb_bar_if.sink                    i_bar,
    input  logic [pfcb_pkg::BOX_W-1:0]  i_box,
    input  pfcb_pkg::t_fifo_stat        i_fifo_stat,
    output logic                        o_push,
    output logic [PRICE_BITS-1:0]       o_hi,
    output logic [PRICE_BITS-1:0]       o_lo,
    output logic [PRICE_BITS-1:0]       o_floor_hi,
    output logic [PRICE_BITS-1:0]       o_floor_lo,
    output pfcb_pkg::t_bar_flags        o_flags
);
    import pfcb_pkg::*;

    localparam int P     = PRICE_BITS;
    localparam int XW    = (P > BOX_W) ? P : BOX_W;
    localparam int CNT_W = $clog2(P + 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [P-1:0]     r_hi;
    logic [P-1:0]     r_lo;
    logic [P-1:0]     r_dv_hi;
    logic [P-1:0]     r_dv_lo;
    logic [BOX_W-1:0] r_rem_hi;
    logic [BOX_W-1:0] r_rem_lo;
    t_bar_flags       r_flags;

    logic [P-1:0]     hi_in;
    logic [P-1:0]     lo_in;
    logic [P-1:0]     cl_in;
    logic [P:0]       hl_sum;
    logic             take;

    // one restoring step of the remainder
    function automatic logic [BOX_W-1:0] rem_step(input logic [BOX_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [BOX_W-1:0] box);
        logic [BOX_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, box}) begin
            return BOX_W'(t - {1'b0, box});
        end
        return t[BOX_W-1:0];
    endfunction

    assign hi_in  = P'(i_bar.bar_high);
    assign lo_in  = P'(i_bar.bar_low);
    assign cl_in  = P'(i_bar.bar_close);
    assign hl_sum = {1'b0, hi_in} + {1'b0, lo_in};
    assign take   = (r_state == S_IDLE) && i_bar.valid;

    assign i_bar.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_bar.valid) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(P - 1)) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_fifo_stat.full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_hi           <= hi_in;
            r_lo           <= lo_in;
            r_dv_hi        <= hi_in;
            r_dv_lo        <= lo_in;
            r_rem_hi       <= '0;
            r_rem_lo       <= '0;
            r_flags.first  <= i_bar.first_bar;
            r_flags.last   <= i_bar.last_bar;
            r_flags.rising <= hl_sum > {cl_in, 1'b0};
        end else if (r_state == S_DIV) begin
            r_rem_hi <= rem_step(r_rem_hi, r_dv_hi[P-1], i_box);
            r_rem_lo <= rem_step(r_rem_lo, r_dv_lo[P-1], i_box);
            r_dv_hi  <= r_dv_hi << 1;
            r_dv_lo  <= r_dv_lo << 1;
        end
    end

    // remainder never exceeds the price, so floor = price - remainder
    assign o_floor_hi = P'(XW'(r_hi) - XW'(r_rem_hi));
    assign o_floor_lo = P'(XW'(r_lo) - XW'(r_rem_lo));
    assign o_hi       = r_hi;
    assign o_lo       = r_lo;
    assign o_flags    = r_flags;
    assign o_push     = (r_state == S_PUSH) && !i_fifo_stat.full;

endmodule

// ===== rtl/pfcb_back.sv =====
// Back half: column state update, reversal and flush results, output stage
`timescale 1ns / 1ps
module pfcb_back #(
    parameter int PRICE_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pfcb_pkg::BOX_W-1:0]  i_box,
    input  logic [pfcb_pkg::TURN_W-1:0] i_turn,
    input  pfcb_pkg::t_fifo_stat        i_fifo_stat,
    input  logic [PRICE_BITS-1:0]       i_hi,
    input  logic [PRICE_BITS-1:0]       i_lo,
    input  logic [PRICE_BITS-1:0]       i_floor_hi,
    input  logic [PRICE_BITS-1:0]       i_floor_lo,
    input  pfcb_pkg::t_bar_flags        i_flags,
    output logic                        o_pop,
    pfcb_col_if.source                  o_col
);
    import pfcb_pkg::*;

    localparam int P  = PRICE_BITS;
    localparam int CW = ((P > TURN_W) ? P : TURN_W) + 1;

    logic         r_started;
    logic         r_rising;
    logic [P-1:0] r_top;
    logic [P-1:0] r_bot;
    logic         r_out_valid;
    t_col_res     r_out;
    logic         r_pend_valid;
    t_col_res     r_pend;

    logic         slot_free;
    logic         take;
    logic [CW-1:0] hi_c, lo_c, box_c, turn_c, top_c, bot_c;
    logic         n_started, n_rising;
    logic [P-1:0] n_top, n_bot;
    logic         rev_hit, flush;
    t_col_res     res_rev, res_fl;

    assign slot_free = !r_out_valid || o_col.ready;
    assign take      = slot_free && !r_pend_valid && !i_fifo_stat.empty;
    assign o_pop     = take;

    assign hi_c   = CW'(i_hi);
    assign lo_c   = CW'(i_lo);
    assign box_c  = CW'(i_box);
    assign turn_c = CW'(i_turn);
    assign top_c  = CW'(r_top);
    assign bot_c  = CW'(r_bot);

    always_comb begin
        n_started = r_started;
        n_rising  = r_rising;
        n_top     = r_top;
        n_bot     = r_bot;
        rev_hit   = 1'b0;
        if (i_flags.first) begin
            n_started = 1'b1;
            n_rising  = i_flags.rising;
            n_top     = i_floor_hi;
            n_bot     = i_floor_lo;
        end else if (r_started) begin
            if (!r_rising) begin
                if (lo_c + box_c <= bot_c) begin
                    n_bot = i_floor_lo;
                end else if (hi_c >= bot_c + turn_c) begin
                    rev_hit  = 1'b1;
                    n_rising = 1'b1;
                    n_bot    = P'(bot_c + box_c);
                    n_top    = i_floor_hi;
                end
            end else begin
                if (hi_c >= top_c + box_c) begin
                    n_top = i_floor_hi;
                end else if (lo_c + turn_c <= top_c) begin
                    rev_hit  = 1'b1;
                    n_rising = 1'b0;
                    n_top    = P'(top_c - box_c);
                    n_bot    = i_floor_lo;
                end
            end
        end
        flush = i_flags.last && n_started;

        res_rev.column_top    = FIELD_W'(r_top);
        res_rev.column_bottom = FIELD_W'(r_bot);
        res_rev.column_rising = r_rising;
        res_rev.open_flushed  = 1'b0;
        res_rev.last_of_run   = !flush;

        res_fl.column_top     = FIELD_W'(n_top);
        res_fl.column_bottom  = FIELD_W'(n_bot);
        res_fl.column_rising  = n_rising;
        res_fl.open_flushed   = 1'b1;
        res_fl.last_of_run    = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_rising     <= 1'b0;
            r_top        <= '0;
            r_bot        <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_pend_valid) begin
                r_out        <= r_pend;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (take) begin
                r_started <= n_started && !flush;
                r_rising  <= n_rising;
                r_top     <= n_top;
                r_bot     <= n_bot;
                if (rev_hit) begin
                    r_out        <= res_rev;
                    r_out_valid  <= 1'b1;
                    r_pend       <= res_fl;
                    r_pend_valid <= flush;
                end else begin
                    r_out       <= res_fl;
                    r_out_valid <= flush;
                end
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_col.valid         = r_out_valid;
    assign o_col.column_top    = r_out.column_top;
    assign o_col.column_bottom = r_out.column_bottom;
    assign o_col.column_rising = r_out.column_rising;
    assign o_col.open_flushed  = r_out.open_flushed;
    assign o_col.last_of_run   = r_out.last_of_run;

endmodule

// ===== rtl/point_figure_column_builder.sv =====
// Path: the front half floors high and low to the box grid in a one-bit-per-cycle
//   remainder loop, the queue holds the result, and the back half updates the column
//   and loads the output register. The front takes no new bar until it has pushed the last.
// A bar that closes a column and flushes gives two results, the closed column first, then the flush.
// Reset (i_rst_n low, synchronous): box_size 1, reversal_boxes 3, no series open,
//   queue and output stage empty; no clearing pass.
`timescale 1ns / 1ps
`include "point_figure_column_builder_assert.svh"
module point_figure_column_builder #(
    parameter int PRICE_BITS = 32   // 8 .. 48
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pfcb_bar_if.sink                     i_bar,
    pfcb_col_if.source                   o_col,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfcb_pkg::ADDR_W-1:0]  paddr,
    input  logic [pfcb_pkg::DATA_W-1:0]  pwdata,
    output logic [pfcb_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import pfcb_pkg::*;

    localparam int P      = PRICE_BITS;
    localparam int FL_W   = $bits(t_bar_flags);
    localparam int Q_W    = 4 * P + FL_W;
    localparam int Q_DEPTH = 2;

    // configuration registers
    logic [BOX_W-1:0]  r_box;
    logic [REV_W-1:0]  r_rev;
    logic [TURN_W-1:0] r_turn;
    logic [BOX_W-1:0]  w_box;
    logic              w_cfg_wr;
    t_reg_idx          w_reg_idx;

    // front to queue
    logic              w_push;
    logic [P-1:0]      w_f_hi, w_f_lo, w_f_fhi, w_f_flo;
    t_bar_flags        w_f_flags;
    logic [Q_W-1:0]    w_q_in;
    logic [Q_W-1:0]    w_q_out;
    t_fifo_stat        w_fifo_stat;

    // queue to back
    logic              w_pop;
    logic [P-1:0]      w_b_hi, w_b_lo, w_b_fhi, w_b_flo;
    t_bar_flags        w_b_flags;

    // ---------------------------------------------------------------
    // APB register file. Writes complete in the access phase; pready
    // is tied high so there are no wait states.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = t_reg_idx'(paddr[ADDR_LSB]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= BOX_RESET;
            r_rev <= REV_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_BOX_SIZE: r_box <= pwdata[BOX_W-1:0];
                REG_REVERSAL: r_rev <= pwdata[REV_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_BOX_SIZE: prdata = DATA_W'(r_box);
            REG_REVERSAL: prdata = DATA_W'(r_rev);
        endcase
    end

    // a box of zero acts as one tick
    assign w_box = (r_box == '0) ? BOX_W'(1) : r_box;

    // turn distance (reversal + 1) boxes, registered and refreshed every cycle; it
    // settles in the cycle after a config write lands in the registers
    always_ff @(posedge i_clk) begin
        r_turn <= (TURN_W'(r_rev) + TURN_W'(1)) * TURN_W'(w_box);
    end

    // ---------------------------------------------------------------
    // Front: bar intake, first-bar direction, box flooring
    // ---------------------------------------------------------------
    pfcb_front #(
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bar       (i_bar),
        .i_box       (w_box),
        .i_fifo_stat (w_fifo_stat),
        .o_push      (w_push),
        .o_hi        (w_f_hi),
        .o_lo        (w_f_lo),
        .o_floor_hi  (w_f_fhi),
        .o_floor_lo  (w_f_flo),
        .o_flags     (w_f_flags)
    );

    // ---------------------------------------------------------------
    // Queue of classified bars between the halves
    // ---------------------------------------------------------------
    assign w_q_in = {w_f_hi, w_f_lo, w_f_fhi, w_f_flo, w_f_flags};

    pfcb_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_stat  (w_fifo_stat)
    );

    assign w_b_hi    = w_q_out[Q_W-1 -: P];
    assign w_b_lo    = w_q_out[Q_W-1-P -: P];
    assign w_b_fhi   = w_q_out[Q_W-1-2*P -: P];
    assign w_b_flo   = w_q_out[Q_W-1-3*P -: P];
    assign w_b_flags = t_bar_flags'(w_q_out[FL_W-1:0]);

    // ---------------------------------------------------------------
    // Back: column state machine and result stage with a one-deep
    // holding slot for the flush that follows a reversal
    // ---------------------------------------------------------------
    pfcb_back #(
        .PRICE_BITS (PRICE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box       (w_box),
        .i_turn      (r_turn),
        .i_fifo_stat (w_fifo_stat),
        .i_hi        (w_b_hi),
        .i_lo        (w_b_lo),
        .i_floor_hi  (w_b_fhi),
        .i_floor_lo  (w_b_flo),
        .i_flags     (w_b_flags),
        .o_pop       (w_pop),
        .o_col       (o_col)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `PFCB_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, !w_fifo_stat.full, "push into full queue")
    `PFCB_ASSERT_IMP(a_pop_data, i_clk, i_rst_n, w_pop, !w_fifo_stat.empty, "pop from empty queue")
    `PFCB_ASSERT_NXT(a_front_busy, i_clk, i_rst_n, i_bar.valid && i_bar.ready, !i_bar.ready, "front not busy after request")
    `PFCB_ASSERT_IMP(a_flush_last, i_clk, i_rst_n, o_col.valid && o_col.open_flushed, o_col.last_of_run, "flush not final result")

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the point-and-figure column builder: directed and random bar streams
`timescale 1ns / 1ps
module testbench;
    import pfcb_pkg::*;

    localparam int          PRICE_BITS   = 32;
    // Drain wait sized from PRICE_BITS with margin, for bars that emit nothing
    localparam int          DRAIN_CYCLES = 3 * (PRICE_BITS + 3);
    // Limit on cycles with no handshake, many times the longest legal quiet stretch
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned REPORT_CAP   = 50;
    localparam longint      PRICE_MAX    = 64'hFFFF_FFFF;
    localparam logic [63:0] PRICE_MASK   = 64'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB side
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    pfcb_bar_if bar_ch ();
    pfcb_col_if col_ch ();

    point_figure_column_builder #(
        .PRICE_BITS(PRICE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bar   (bar_ch),
        .o_col   (col_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Column predictor: config shadow plus the open column
    // ------------------------------------------------------------------
    logic [BOX_W-1:0] cfg_box     = BOX_RESET;
    logic [REV_W-1:0] cfg_rev     = REV_RESET;
    logic             pf_started  = 1'b0;
    logic             pf_rising   = 1'b0;
    logic [63:0]      pf_top      = '0;
    logic [63:0]      pf_bottom   = '0;
    int unsigned      bars_used   = 0;   // bars the block acts on (ignored ones excluded)
    int unsigned      fail_count  = 0;
    int unsigned      quiet_cycles = 0;
    t_col_res         col_expect[$];     // predicted columns, oldest first

    function automatic logic [63:0] grid_floor(logic [63:0] price, logic [63:0] box);
        return (price / box) * box;
    endfunction

    function automatic t_col_res column_now(logic flushed);
        t_col_res c;
        c.column_top    = pf_top[FIELD_W-1:0];
        c.column_bottom = pf_bottom[FIELD_W-1:0];
        c.column_rising = pf_rising;
        c.open_flushed  = flushed;
        c.last_of_run   = 1'b0;
        return c;
    endfunction

    function automatic void predict_columns(logic [31:0] hi32, logic [31:0] lo32,
                                            logic [31:0] cl32, logic first, logic last);
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] cl;
        logic [63:0] box;
        logic [63:0] turn;
        t_col_res    made[$];
        hi   = {32'd0, hi32};
        lo   = {32'd0, lo32};
        cl   = {32'd0, cl32};
        // zero box size behaves as one tick
        box  = (cfg_box == '0) ? 64'd1 : {32'd0, cfg_box};
        turn = ({60'd0, cfg_rev} + 64'd1) * box;
        if (first || pf_started)
            bars_used++;
        if (first) begin
            // a start while a column is open drops it silently
            pf_started = 1'b1;
            pf_rising  = (hi + lo) > (cl << 1);
            pf_top     = grid_floor(hi, box);
            pf_bottom  = grid_floor(lo, box);
        end else if (pf_started) begin
            if (!pf_rising) begin
                if (lo + box <= pf_bottom) begin
                    pf_bottom = grid_floor(lo, box);
                end else if (hi >= pf_bottom + turn) begin
                    made.push_back(column_now(1'b0));
                    pf_rising = 1'b1;
                    pf_bottom = (pf_bottom + box) & PRICE_MASK;
                    pf_top    = grid_floor(hi, box);
                end
            end else begin
                if (hi >= pf_top + box) begin
                    pf_top = grid_floor(hi, box);
                end else if (lo + turn <= pf_top) begin
                    made.push_back(column_now(1'b0));
                    pf_rising = 1'b0;
                    pf_top    = pf_top - box;
                    pf_bottom = grid_floor(lo, box);
                end
            end
        end
        if (last && pf_started) begin
            made.push_back(column_now(1'b1));
            pf_started = 1'b0;
        end
        if (made.size() != 0)
            made[$].last_of_run = 1'b1;
        foreach (made[i])
            col_expect.push_back(made[i]);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted column against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : col_check
        t_col_res want;
        if (i_rst_n && col_ch.valid && col_ch.ready) begin
            if (col_expect.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $error("column top %0d bottom %0d arrived with none predicted",
                           col_ch.column_top, col_ch.column_bottom);
            end else begin
                want = col_expect.pop_front();
                check_field("column_top", want.column_top, col_ch.column_top);
                check_field("column_bottom", want.column_bottom, col_ch.column_bottom);
                check_field("column_rising", 32'(want.column_rising), 32'(col_ch.column_rising));
                check_field("open_flushed", 32'(want.open_flushed), 32'(col_ch.open_flushed));
                check_field("last_of_run", 32'(want.last_of_run), 32'(col_ch.last_of_run));
            end
        end
    end

    // ------------------------------------------------------------------
    // Column receiver: its own stall pattern, switching mode after a random
    // run length so stalls land on every phase, including between the
    // two columns of a reversal-plus-flush bar.
    // ------------------------------------------------------------------
    int unsigned rx_mode  = 0;
    int unsigned rx_left  = 0;
    int unsigned rx_stall = 0;

    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        if (rx_stall != 0) begin
            col_ch.ready <= 1'b0;
            rx_stall     <= rx_stall - 1;
        end else begin
            case (rx_mode)
                0: col_ch.ready <= 1'b1;                        // free flowing
                1: col_ch.ready <= ~col_ch.ready;               // alternating
                2: col_ch.ready <= ($urandom_range(0, 3) != 0);
                default: begin                                  // rare long stalls
                    col_ch.ready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        rx_stall <= $urandom_range(1, 60);
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run after too long with no handshake anywhere
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((bar_ch.valid && bar_ch.ready) || (col_ch.valid && col_ch.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Bar sender: bursts of random length, random gaps between them
    // ------------------------------------------------------------------
    int unsigned tx_burst = 0;

    task automatic send_bar(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] cl, input logic first, input logic last);
        int unsigned gap;
        gap = 0;
        if (tx_burst == 0) begin
            tx_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 45) : $urandom_range(1, 3);
        end else begin
            tx_burst--;
        end
        @(negedge i_clk);
        if (gap != 0) begin
            bar_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        bar_ch.valid     <= 1'b1;
        bar_ch.bar_high  <= hi;
        bar_ch.bar_low   <= lo;
        bar_ch.bar_close <= cl;
        bar_ch.first_bar <= first;
        bar_ch.last_bar  <= last;
        do @(posedge i_clk); while (!bar_ch.ready);
        predict_columns(hi, lo, cl, first, last);
    endtask

    // Drop valid, let every predicted column arrive, then let the pipe empty
    task automatic wait_drained();
        @(negedge i_clk);
        bar_ch.valid <= 1'b0;
        while (col_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(int'(idx) << ADDR_LSB);
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr) begin
            if (idx == REG_BOX_SIZE)
                cfg_box = wdata;
            else
                cfg_rev = wdata[REV_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Registers change only with the block idle; both are read back
    task automatic set_config(input logic [31:0] box, input logic [REV_W-1:0] rev);
        logic [31:0] rd;
        wait_drained();
        apb_access(1'b1, REG_BOX_SIZE, box, rd);
        apb_access(1'b1, REG_REVERSAL, {28'd0, rev}, rd);
        apb_access(1'b0, REG_BOX_SIZE, 32'd0, rd);
        check_field("box_size readback", box, rd);
        apb_access(1'b0, REG_REVERSAL, 32'd0, rd);
        check_field("reversal_boxes readback", {28'd0, rev}, {28'd0, rd[REV_W-1:0]});
    endtask

    function automatic longint clamp_price(longint x);
        if (x < 0)
            return 0;
        if (x > PRICE_MAX)
            return PRICE_MAX;
        return x;
    endfunction

    // Random series: a start, a trending walk that reverses now and then,
    // usually a closing last bar. About one series in ten is a single bar of pure noise.
    task automatic run_walks(input int unsigned count);
        int unsigned goal;
        int unsigned len;
        int unsigned k;
        int          dir;
        longint      mid;
        longint      span;
        longint      hi;
        longint      lo;
        longint      cl;
        longint      tmp;
        logic [63:0] box;
        logic        last;
        goal = bars_used + count;
        box  = (cfg_box == '0) ? 64'd1 : {32'd0, cfg_box};
        while (bars_used < goal) begin
            if ($urandom_range(0, 9) == 0) begin
                send_bar($urandom, $urandom, $urandom,
                         $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end else begin
                case ($urandom_range(0, 3))
                    0:       mid = longint'($urandom_range(0, 64));
                    1:       mid = PRICE_MAX - longint'($urandom_range(0, 64));
                    default: mid = longint'($urandom);
                endcase
                dir = $urandom_range(0, 1) ? 1 : -1;
                len = $urandom_range(0, 24);
                for (k = 0; k <= len; k++) begin
                    if ($urandom_range(0, 3) == 0)
                        dir = -dir;
                    span = longint'($urandom_range(0, int'(cfg_rev) + 2)) * longint'(box);
                    mid  = clamp_price(mid + dir * span);
                    hi   = clamp_price(mid + longint'($urandom_range(0, box[31:0])));
                    lo   = clamp_price(mid - longint'($urandom_range(0, box[31:0])));
                    if ($urandom_range(0, 15) == 0) begin   // inverted bar
                        tmp = hi;
                        hi  = lo;
                        lo  = tmp;
                    end
                    case ($urandom_range(0, 2))
                        0:       cl = hi;
                        1:       cl = lo;
                        default: cl = longint'($urandom);
                    endcase
                    last = (k == len) && ($urandom_range(0, 7) != 0);
                    send_bar(32'(hi), 32'(lo), 32'(cl), k == 0, last);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config (box 1, turn of 4 boxes): hand-built bars for each case
    task automatic test_directed_cases();
        // bar before any start, with last set: ignored, nothing out
        send_bar(32'd5, 32'd3, 32'd4, 1'b0, 1'b1);
        // rising start, extend, then a reversal on an inverted bar
        send_bar(32'd100, 32'd50, 32'd60, 1'b1, 1'b0);
        send_bar(32'd110, 32'd104, 32'd0, 1'b0, 1'b0);
        send_bar(32'd105, 32'd106, 32'd0, 1'b0, 1'b0);
        // falling extend, then reversal and flush on one bar: two columns
        send_bar(32'd107, 32'd90, 32'd0, 1'b0, 1'b0);
        send_bar(32'd120, 32'd95, 32'd0, 1'b0, 1'b1);
        // first and last on the same bar
        send_bar(32'd200, 32'd100, 32'd150, 1'b1, 1'b1);
        // restart mid-series drops the open column
        send_bar(32'd300, 32'd250, 32'd200, 1'b1, 1'b0);
        send_bar(32'd400, 32'd10, 32'd900, 1'b1, 1'b0);
        send_bar(32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
        // non-first bar after the flush: ignored
        send_bar(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // price extremes, 64-bit compares near the top of the range
        send_bar(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b1, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
        send_bar(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        // alternating bit patterns
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'h0F0F_0F0F, 1'b1, 1'b0);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'hF0F0_F0F0, 1'b0, 1'b1);
    endtask

    task automatic test_default_walks();
        run_walks(250);
    endtask

    // Every reversal count, small boxes so turns happen often
    task automatic test_reversal_sweep();
        int r;
        for (r = 0; r < 16; r++) begin
            set_config(32'($urandom_range(1, 64)), REV_W'(r));
            run_walks(25);
        end
    endtask

    // Sender holds off mid-stream until every predicted column is out
    task automatic test_drain_pause();
        set_config(32'($urandom_range(1, 1000)), REV_W'($urandom_range(0, 15)));
        run_walks(100);
        wait_drained();
        run_walks(100);
    endtask

    // Box size zero acts as one tick
    task automatic test_zero_box();
        set_config(32'd0, 4'd0);
        send_bar(32'd10, 32'd9, 32'd10, 1'b1, 1'b0);
        send_bar(32'd8, 32'd8, 32'd0, 1'b0, 1'b0);
        send_bar(32'd10, 32'd10, 32'd0, 1'b0, 1'b1);
        run_walks(100);
    endtask

    // Widest box and longest turn, then a random wide box
    task automatic test_wide_box();
        set_config(32'hFFFF_FFFF, 4'd15);
        send_bar(32'hFFFF_FFFF, 32'd0, 32'd1, 1'b1, 1'b0);
        send_bar(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b1);
        run_walks(60);
        set_config($urandom, REV_W'($urandom_range(0, 15)));
        run_walks(100);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        bar_ch.valid     = 1'b0;
        bar_ch.bar_high  = '0;
        bar_ch.bar_low   = '0;
        bar_ch.bar_close = '0;
        bar_ch.first_bar = 1'b0;
        bar_ch.last_bar  = 1'b0;
        col_ch.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_default_walks();
        test_reversal_sweep();
        test_drain_pause();
        test_zero_box();
        test_wide_box();

        wait_drained();
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pfcb_pkg.sv
rtl/pfcb_if.sv
rtl/pfcb_fifo.sv
rtl/pfcb_front.sv
rtl/pfcb_back.sv
rtl/point_figure_column_builder.sv
verif/testbench.sv
